FILE: src/lbq_pkg.sv
// ----------------------------------------------------------------------------
// lbq_pkg
// Shared types, widths and codes for the leaky-bucket queue shaper.
// ----------------------------------------------------------------------------
package lbq_pkg;

  // field widths fixed by the interface
  localparam int unsigned TAG_BITS      = 16;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned CNT_BITS      = 5;
  localparam int unsigned LIMIT_BITS    = 5;
  localparam int unsigned SVC_BITS      = 16;
  localparam int unsigned STATUS_BITS   = 3;
  localparam int unsigned CFG_ADDR_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 16;

  // default queue depth
  localparam int unsigned DEF_QUEUE_DEPTH = 16;

  // reset values of the configuration registers
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;
  localparam logic [SVC_BITS-1:0]   SVC_RESET   = 16'd1;

  // configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_BUFFER_LIMIT  = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_SERVICE_TICKS = 2'd1;

  // input word kind
  typedef enum logic [0:0] {
    OP_TICK   = 1'b0,
    OP_ARRIVE = 1'b1
  } lbq_op_t;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    ST_NONE     = 3'd0,
    ST_SERVED   = 3'd1,
    ST_QUEUED   = 3'd2,
    ST_DROPPED  = 3'd3,
    ST_DEPARTED = 3'd4
  } lbq_status_t;

  // classified word between front and back
  typedef struct packed {
    lbq_op_t             op;
    logic [TAG_BITS-1:0] tag;
  } lbq_cmd_t;

  // one result word
  typedef struct packed {
    lbq_status_t          status;
    logic [TAG_BITS-1:0]  out_tag;
    logic                 started;
    logic [TIME_BITS-1:0] wait_ticks;
    logic [CNT_BITS-1:0]  queue_length;
    logic                 busy;
  } lbq_res_t;

endpackage

FILE: src/leaky_bucket_queue.sv
// ----------------------------------------------------------------------------
// leaky_bucket_queue
// Leaky-bucket packet shaper: one server with a finite waiting queue.
// ----------------------------------------------------------------------------
// Input words carry a kind in in_tuser (0 tick, 1 packet arrival) and the
// packet tag in in_tdata. Every accepted word yields exactly one result word
// with status, departing tag, service-start flag, waiting time, queue length
// and server busy flag.
// Each word passes the input queue, then the result register, on its way out.
// Throughput: one word per cycle while out_tready is high, as the back end
// updates its state once per word; the queue memory is read ahead into
// registers at the next head slot. Configuration (buffer_limit at index 0,
// service_ticks at index 1) goes through cfg_we/cfg_addr/cfg_wdata; the user
// must write it only while the block is idle, the block does not enforce it.
// Reset: empty queue, idle server, time zero, buffer_limit 16, service_ticks 1;
// no clearing pass is needed, entries are read only after being written.
// When out_tready is low the result word holds, the two-word input queue
// fills, and in_tready then drops until the receiver takes the result.
// ----------------------------------------------------------------------------
module leaky_bucket_queue #(
  parameter int unsigned QUEUE_DEPTH = lbq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [15:0]                       in_tdata,  // [15:0] packet_tag
  input  logic [0:0]                        in_tuser,  // [0] kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] out_tag, [47:16] wait_ticks, [52:48] queue_length, [53] busy_res
  output logic [55:0]                       out_tdata,
  output logic [3:0]                        out_tuser, // [2:0] status, [3] started_valid
  input  logic                              cfg_we,
  input  logic [lbq_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [lbq_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  logic              cmd_valid;
  logic              cmd_ready;
  lbq_pkg::lbq_cmd_t cmd;
  lbq_pkg::lbq_res_t res;

  // accept and classify
  lbq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser[0]),
    .in_tag    (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // queue and server update
  lbq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the result word
  assign out_tdata = {2'b00, res.busy, res.queue_length, res.wait_ticks, res.out_tag};
  assign out_tuser = {res.started, res.status};

endmodule

FILE: src/lbq_front.sv
// ----------------------------------------------------------------------------
// lbq_front
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lbq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [lbq_pkg::TAG_BITS-1:0] in_tag,
  output logic                         cmd_valid,
  input  logic                         cmd_ready,
  output lbq_pkg::lbq_cmd_t            cmd
);

  lbq_pkg::lbq_cmd_t ent_r [2];
  lbq_pkg::lbq_cmd_t in_cmd;
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              push, pop;

  // classify the incoming word
  always_comb begin
    in_cmd.op  = in_kind ? lbq_pkg::OP_ARRIVE : lbq_pkg::OP_TICK;
    in_cmd.tag = in_tag;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = ent_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

FILE: src/lbq_back.sv
// ----------------------------------------------------------------------------
// lbq_back
// Server and waiting-queue state, configuration registers and result register.
// ----------------------------------------------------------------------------
module lbq_back #(
  parameter int unsigned QUEUE_DEPTH = lbq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  lbq_pkg::lbq_cmd_t                 cmd,
  input  logic                              cfg_we,
  input  logic [lbq_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [lbq_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output logic                              res_valid,
  input  logic                              res_ready,
  output lbq_pkg::lbq_res_t                 res
);

  localparam int unsigned IDX_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned DEPTH_CAP = (QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH;
  localparam logic [lbq_pkg::CNT_BITS-1:0] CAP = lbq_pkg::CNT_BITS'(DEPTH_CAP);
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(QUEUE_DEPTH - 1);

  // waiting queue storage
  logic [lbq_pkg::TAG_BITS-1:0]  mem_tag   [QUEUE_DEPTH];
  logic [lbq_pkg::TIME_BITS-1:0] mem_stamp [QUEUE_DEPTH];
  logic [lbq_pkg::TAG_BITS-1:0]  rd_tag_r;
  logic [lbq_pkg::TIME_BITS-1:0] rd_stamp_r;

  // configuration
  logic [lbq_pkg::LIMIT_BITS-1:0] limit_r;
  logic [lbq_pkg::SVC_BITS-1:0]   svc_r;
  logic [lbq_pkg::CNT_BITS-1:0]   eff_limit;
  logic [lbq_pkg::SVC_BITS-1:0]   svc_len;

  // server state
  logic [IDX_BITS-1:0]           head_r, head_nxt;
  logic [IDX_BITS-1:0]           tail_r, tail_nxt;
  logic [lbq_pkg::CNT_BITS-1:0]  count_r, count_nxt;
  logic                          busy_r, busy_nxt;
  logic [lbq_pkg::TAG_BITS-1:0]  served_r, served_nxt;
  logic [lbq_pkg::SVC_BITS-1:0]  rem_r, rem_nxt, rem_dec;
  logic [lbq_pkg::TIME_BITS-1:0] now_r, now_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  lbq_pkg::lbq_res_t out_r, res_nxt;

  logic fire;
  logic mem_we;

  function automatic logic [IDX_BITS-1:0] next_slot(input logic [IDX_BITS-1:0] i);
    next_slot = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign cmd_ready = !out_valid_r || res_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  assign eff_limit = (limit_r > CAP) ? CAP : limit_r;
  assign svc_len   = (svc_r == '0) ? lbq_pkg::SVC_BITS'(1) : svc_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lbq_pkg::LIMIT_RESET;
      svc_r   <= lbq_pkg::SVC_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        lbq_pkg::CFG_BUFFER_LIMIT:  limit_r <= cfg_wdata[lbq_pkg::LIMIT_BITS-1:0];
        lbq_pkg::CFG_SERVICE_TICKS: svc_r   <= cfg_wdata[lbq_pkg::SVC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // one queue update per word
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    busy_nxt   = busy_r;
    served_nxt = served_r;
    rem_nxt    = rem_r;
    now_nxt    = now_r;
    mem_we     = 1'b0;
    rem_dec    = (rem_r != '0) ? rem_r - 1'b1 : rem_r;

    res_nxt.status     = lbq_pkg::ST_NONE;
    res_nxt.out_tag    = '0;
    res_nxt.started    = 1'b0;
    res_nxt.wait_ticks = '0;

    if (fire) begin
      if (cmd.op == lbq_pkg::OP_TICK) begin
        // time first, then the service countdown
        now_nxt = now_r + 1'b1;
        if (busy_r) begin
          rem_nxt = rem_dec;
          if (rem_dec == '0) begin
            res_nxt.status  = lbq_pkg::ST_DEPARTED;
            res_nxt.out_tag = served_r;
            if (count_r != '0) begin
              // head of queue enters service
              served_nxt         = rd_tag_r;
              res_nxt.wait_ticks = now_nxt - rd_stamp_r;
              res_nxt.started    = 1'b1;
              head_nxt           = next_slot(head_r);
              count_nxt          = count_r - 1'b1;
              rem_nxt            = svc_len;
            end else begin
              busy_nxt = 1'b0;
            end
          end
        end
      end else if (!busy_r) begin
        // idle server takes the packet at once
        served_nxt      = cmd.tag;
        busy_nxt        = 1'b1;
        rem_nxt         = svc_len;
        res_nxt.status  = lbq_pkg::ST_SERVED;
        res_nxt.started = 1'b1;
      end else if (count_r < eff_limit) begin
        mem_we         = 1'b1;
        tail_nxt       = next_slot(tail_r);
        count_nxt      = count_r + 1'b1;
        res_nxt.status = lbq_pkg::ST_QUEUED;
      end else begin
        res_nxt.status = lbq_pkg::ST_DROPPED;
      end
    end

    res_nxt.queue_length = count_nxt;
    res_nxt.busy         = busy_nxt;
    out_valid_nxt        = fire || (out_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      busy_r      <= 1'b0;
      rem_r       <= '0;
      now_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      rem_r       <= rem_nxt;
      now_r       <= now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    served_r <= served_nxt;
    if (fire) begin
      out_r <= res_nxt;
    end
  end

  // queue memory, read data tracks the next head with write bypass
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_tag[tail_r]   <= cmd.tag;
      mem_stamp[tail_r] <= now_r;
    end
    if (mem_we && (tail_r == head_nxt)) begin
      rd_tag_r   <= cmd.tag;
      rd_stamp_r <= now_r;
    end else begin
      rd_tag_r   <= mem_tag[head_nxt];
      rd_stamp_r <= mem_stamp[head_nxt];
    end
  end

  // an idle server never leaves packets waiting
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (count_r == '0))
    else $error("packets waiting while server idle");

  // a busy server always has ticks left
  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != '0))
    else $error("busy server with zero countdown");

  // a queued packet grows the queue by one
  a_queue_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (res_nxt.status == lbq_pkg::ST_QUEUED))
      |=> (count_r == $past(count_r) + lbq_pkg::CNT_BITS'(1)))
    else $error("queue count did not grow on enqueue");

  // a start of service comes only with an immediate serve or a departure
  a_start_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.started)
      |-> ((out_r.status == lbq_pkg::ST_SERVED) || (out_r.status == lbq_pkg::ST_DEPARTED)))
    else $error("service start with wrong status");

endmodule
